// ===== rtl/ies_pkg.sv =====
package ies_pkg;

   // field widths
   localparam int E_W      = 21;
   localparam int NU_W     = 17;
   localparam int STRAIN_W = 32;
   localparam int STRESS_W = 48;

   // lane layout in full 3D: three normal components, three shear components
   localparam int LANES   = 6;
   localparam int NORMALS = 3;

   // internal datapath widths
   localparam int COEF_W = 19;                  // (1+nu), (1-nu), (1-2nu) in q16
   localparam int DENF_W = 2 * COEF_W;          // full product of two coefficients
   localparam int SUM_W  = STRAIN_W + 1;        // sum of two strains
   localparam int PROD_W = COEF_W + SUM_W;      // coefficient times strain sum
   localparam int MAG_W  = 49;                  // magnitude of the weighted strain
   localparam int K_W    = E_W + 2;             // 4 * E
   localparam int LO_W   = 32;                  // low slice of the magnitude
   localparam int HI_W   = MAG_W - LO_W;        // high slice of the magnitude
   localparam int PLO_W  = K_W + LO_W;
   localparam int PHI_W  = K_W + HI_W;
   localparam int DEN_W  = 36;                  // divisor, always below 2^35
   localparam int NUM_W  = 73;                  // rounded dividend
   localparam int QUO_W  = STRESS_W;            // quotient bits produced
   localparam int FRONT  = 4;                   // stages ahead of the divider
   localparam int STAGES = FRONT + QUO_W + 1;

   // fixed point constants
   localparam int ONE_Q16 = 65536;
   localparam int NU_MAX  = 32767;
   localparam int NU_MIN  = -65535;

   localparam logic [STRESS_W-1:0] POS_LIM = {1'b0, {(STRESS_W-1){1'b1}}};
   localparam logic [STRESS_W-1:0] NEG_LIM = {1'b1, {(STRESS_W-1){1'b0}}};

   typedef enum logic {
      MODE_PLANE_STRESS = 1'b0,
      MODE_SOLID        = 1'b1
   } mode_type;

   typedef struct packed {
      logic [LANES-1:0][STRESS_W-1:0] stress;
      logic                           overflow;
   } result_type;

endpackage

// ===== rtl/ies_req_if.sv =====
interface ies_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [ies_pkg::E_W-1:0]         youngs_modulus;
   logic signed [ies_pkg::NU_W-1:0]        poisson_ratio;
   logic signed [ies_pkg::STRAIN_W-1:0]    strain_xx;
   logic signed [ies_pkg::STRAIN_W-1:0]    strain_yy;
   logic signed [ies_pkg::STRAIN_W-1:0]    strain_third;
   logic signed [ies_pkg::STRAIN_W-1:0]    strain_fourth;
   logic signed [ies_pkg::STRAIN_W-1:0]    strain_fifth;
   logic signed [ies_pkg::STRAIN_W-1:0]    strain_sixth;

   modport source (
      output valid, youngs_modulus, poisson_ratio, strain_xx, strain_yy,
             strain_third, strain_fourth, strain_fifth, strain_sixth,
      input  ready
   );

   modport sink (
      input  valid, youngs_modulus, poisson_ratio, strain_xx, strain_yy,
             strain_third, strain_fourth, strain_fifth, strain_sixth,
      output ready
   );
endinterface

// ===== rtl/ies_rsp_if.sv =====
interface ies_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ies_pkg::STRESS_W-1:0]  stress_xx;
   logic signed [ies_pkg::STRESS_W-1:0]  stress_yy;
   logic signed [ies_pkg::STRESS_W-1:0]  stress_third;
   logic signed [ies_pkg::STRESS_W-1:0]  stress_fourth;
   logic signed [ies_pkg::STRESS_W-1:0]  stress_fifth;
   logic signed [ies_pkg::STRESS_W-1:0]  stress_sixth;
   logic                                 overflow;

   modport source (
      output valid, stress_xx, stress_yy, stress_third, stress_fourth,
             stress_fifth, stress_sixth, overflow,
      input  ready
   );

   modport sink (
      input  valid, stress_xx, stress_yy, stress_third, stress_fourth,
             stress_fifth, stress_sixth, overflow,
      output ready
   );
endinterface

// ===== rtl/isotropic_elastic_stress.sv =====
// Isotropic linear elastic stress (Hooke's law) for one material point per word. A new word is
// taken every clock cycle unless the output buffer stalls the pipeline; each word passes four
// arithmetic stages, one stage to form the rounded dividend, 48 restoring division stages and
// one output register, the divider giving one quotient bit per stage in each of six lanes.
// Each stress is rounded once to nearest, ties away from zero, and saturated to 48 bits, with
// overflow raised when any lane saturates. csr_wdata selects plane stress (0, three components,
// outputs four to six read zero) or full 3D (1, reset value); write it only while idle. A
// two-word output buffer lets the pipeline accept while one result waits; a second one stalls it.
module isotropic_elastic_stress (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_wdata,
   ies_req_if.sink    req,
   ies_rsp_if.source  rsp
);

   localparam int LANES  = ies_pkg::LANES;
   localparam int QUO_W  = ies_pkg::QUO_W;
   localparam int DEN_W  = ies_pkg::DEN_W;
   localparam int STAGES = ies_pkg::STAGES;

   // mode register
   ies_pkg::mode_type mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ies_pkg::MODE_SOLID;
      end else if (csr_we) begin
         mode_ff <= ies_pkg::mode_type'(csr_wdata);
      end
   end

   // pipeline control
   logic [STAGES-1:0] vld_ff;
   logic              skid_vld_ff;
   logic              rsp_vld_ff;
   logic              pipe_en;
   logic              leave;

   assign pipe_en   = !skid_vld_ff;
   assign leave     = pipe_en && vld_ff[STAGES-1];
   assign req.ready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[STAGES-2:0], req.valid};
      end
   end

   // stage 0: capture, poisson ratio clamped
   logic        [ies_pkg::E_W-1:0]      e0_ff;
   logic signed [ies_pkg::NU_W-1:0]     n0_ff;
   logic signed [ies_pkg::STRAIN_W-1:0] s0_ff [LANES];
   logic signed [ies_pkg::NU_W-1:0]     n0_in;

   always_comb begin
      n0_in = req.poisson_ratio;
      if (req.poisson_ratio < ies_pkg::NU_W'(ies_pkg::NU_MIN)) begin
         n0_in = ies_pkg::NU_W'(ies_pkg::NU_MIN);
      end else if (req.poisson_ratio > ies_pkg::NU_W'(ies_pkg::NU_MAX)) begin
         n0_in = ies_pkg::NU_W'(ies_pkg::NU_MAX);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         e0_ff    <= req.youngs_modulus;
         n0_ff    <= n0_in;
         s0_ff[0] <= req.strain_xx;
         s0_ff[1] <= req.strain_yy;
         s0_ff[2] <= req.strain_third;
         s0_ff[3] <= req.strain_fourth;
         s0_ff[4] <= req.strain_fifth;
         s0_ff[5] <= req.strain_sixth;
      end
   end

   // stage 1: coefficients, weighted strain products, divisors
   logic signed [ies_pkg::COEF_W-1:0]   n_c;
   logic signed [ies_pkg::COEF_W-1:0]   m_c;
   logic signed [ies_pkg::COEF_W-1:0]   q_c;
   logic signed [ies_pkg::COEF_W-1:0]   p_c;
   logic signed [ies_pkg::COEF_W-1:0]   sel_c;
   logic signed [ies_pkg::DENF_W-1:0]   den_full;
   logic signed [ies_pkg::SUM_W:0]      tot;
   logic signed [ies_pkg::COEF_W-1:0]   c_l  [LANES];
   logic signed [ies_pkg::SUM_W-1:0]    xa_l [LANES];
   logic signed [ies_pkg::SUM_W-1:0]    xb_l [LANES];
   logic        [LANES-1:0]             shear_l;
   logic signed [ies_pkg::PROD_W-1:0]   pa1_in [LANES];
   logic signed [ies_pkg::PROD_W-1:0]   pb1_in [LANES];
   logic        [ies_pkg::K_W-1:0]      k1_in  [LANES];
   logic        [DEN_W-1:0]             d1_in  [LANES];
   logic        [LANES-1:0]             zero1_in;
   logic signed [ies_pkg::PROD_W-1:0]   pa1_ff [LANES];
   logic signed [ies_pkg::PROD_W-1:0]   pb1_ff [LANES];
   logic        [ies_pkg::K_W-1:0]      k1_ff  [LANES];
   logic        [DEN_W-1:0]             d1_ff  [LANES];
   logic        [LANES-1:0]             zero1_ff;

   always_comb begin
      n_c      = ies_pkg::COEF_W'(n0_ff);
      m_c      = ies_pkg::COEF_W'(ies_pkg::ONE_Q16) + n_c;
      q_c      = ies_pkg::COEF_W'(ies_pkg::ONE_Q16) - n_c;
      p_c      = ies_pkg::COEF_W'(ies_pkg::ONE_Q16) - (n_c <<< 1);
      sel_c    = (mode_ff == ies_pkg::MODE_PLANE_STRESS) ? q_c : p_c;
      den_full = ies_pkg::DENF_W'(m_c) * ies_pkg::DENF_W'(sel_c);
      tot      = (ies_pkg::SUM_W+1)'(s0_ff[0]) + (ies_pkg::SUM_W+1)'(s0_ff[1])
               + (ies_pkg::SUM_W+1)'(s0_ff[2]);
      for (int l = 0; l < LANES; l++) begin
         shear_l[l]  = 1'b1;
         c_l[l]      = ies_pkg::COEF_W'(1);
         xa_l[l]     = ies_pkg::SUM_W'(s0_ff[l]);
         xb_l[l]     = '0;
         zero1_in[l] = 1'b0;
         if (l < ies_pkg::NORMALS) begin
            if (mode_ff == ies_pkg::MODE_SOLID) begin
               shear_l[l] = 1'b0;
               c_l[l]     = q_c;
               xb_l[l]    = ies_pkg::SUM_W'(tot - (ies_pkg::SUM_W+1)'(s0_ff[l]));
            end else if (l < 2) begin
               shear_l[l] = 1'b0;
               c_l[l]     = ies_pkg::COEF_W'(ies_pkg::ONE_Q16);
               xb_l[l]    = ies_pkg::SUM_W'(s0_ff[(l == 0) ? 1 : 0]);
            end
         end else if (mode_ff == ies_pkg::MODE_PLANE_STRESS) begin
            zero1_in[l] = 1'b1;
         end
         pa1_in[l] = ies_pkg::PROD_W'(c_l[l]) * ies_pkg::PROD_W'(xa_l[l]);
         pb1_in[l] = ies_pkg::PROD_W'(n_c) * ies_pkg::PROD_W'(xb_l[l]);
         k1_in[l]  = shear_l[l] ? ies_pkg::K_W'({e0_ff, 1'b0}) : {e0_ff, 2'b00};
         d1_in[l]  = shear_l[l] ? DEN_W'(m_c) : DEN_W'(den_full);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         pa1_ff   <= pa1_in;
         pb1_ff   <= pb1_in;
         k1_ff    <= k1_in;
         d1_ff    <= d1_in;
         zero1_ff <= zero1_in;
      end
   end

   // stage 2: weighted strain, sign and magnitude
   logic signed [ies_pkg::PROD_W-1:0] y2 [LANES];
   logic        [ies_pkg::PROD_W-1:0] yabs2 [LANES];
   logic        [ies_pkg::MAG_W-1:0]  a2_in [LANES];
   logic        [LANES-1:0]           neg2_in;
   logic        [ies_pkg::MAG_W-1:0]  a2_ff [LANES];
   logic        [LANES-1:0]           neg2_ff;
   logic        [ies_pkg::K_W-1:0]    k2_ff [LANES];
   logic        [DEN_W-1:0]           d2_ff [LANES];
   logic        [LANES-1:0]           zero2_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         y2[l]      = pa1_ff[l] + pb1_ff[l];
         neg2_in[l] = y2[l][ies_pkg::PROD_W-1];
         yabs2[l]   = neg2_in[l] ? ies_pkg::PROD_W'(-y2[l]) : ies_pkg::PROD_W'(y2[l]);
         a2_in[l]   = yabs2[l][ies_pkg::MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a2_ff    <= a2_in;
         neg2_ff  <= neg2_in;
         k2_ff    <= k1_ff;
         d2_ff    <= d1_ff;
         zero2_ff <= zero1_ff;
      end
   end

   // stage 3: modulus times magnitude as two partial products
   logic [ies_pkg::PLO_W-1:0] plo3_in [LANES];
   logic [ies_pkg::PHI_W-1:0] phi3_in [LANES];
   logic [ies_pkg::PLO_W-1:0] plo3_ff [LANES];
   logic [ies_pkg::PHI_W-1:0] phi3_ff [LANES];
   logic [LANES-1:0]          neg3_ff;
   logic [DEN_W-1:0]          d3_ff [LANES];
   logic [LANES-1:0]          zero3_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         plo3_in[l] = ies_pkg::PLO_W'(k2_ff[l])
                    * ies_pkg::PLO_W'(a2_ff[l][ies_pkg::LO_W-1:0]);
         phi3_in[l] = ies_pkg::PHI_W'(k2_ff[l])
                    * ies_pkg::PHI_W'(a2_ff[l][ies_pkg::MAG_W-1:ies_pkg::LO_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         plo3_ff  <= plo3_in;
         phi3_ff  <= phi3_in;
         neg3_ff  <= neg2_ff;
         d3_ff    <= d2_ff;
         zero3_ff <= zero2_ff;
      end
   end

   // divider stage registers, index 0 holds the rounded dividend
   logic [DEN_W-1:0] dr_ff   [QUO_W+1][LANES];
   logic [QUO_W-1:0] dl_ff   [QUO_W+1][LANES];
   logic [QUO_W-1:0] dq_ff   [QUO_W+1][LANES];
   logic [DEN_W-1:0] dd_ff   [QUO_W+1][LANES];
   logic [LANES-1:0] dneg_ff [QUO_W+1];
   logic [LANES-1:0] dzero_ff[QUO_W+1];
   logic [LANES-1:0] dhuge_ff[QUO_W+1];

   // stage 4: dividend plus half divisor, quotient range check
   logic [ies_pkg::NUM_W-1:0] num4 [LANES];
   logic [DEN_W-1:0]          r4_in [LANES];
   logic [LANES-1:0]          huge4_in;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         num4[l]     = ies_pkg::NUM_W'(plo3_ff[l])
                     + ies_pkg::NUM_W'({phi3_ff[l], {ies_pkg::LO_W{1'b0}}})
                     + ies_pkg::NUM_W'(d3_ff[l][DEN_W-1:1]);
         r4_in[l]    = DEN_W'(num4[l][ies_pkg::NUM_W-1:QUO_W]);
         huge4_in[l] = r4_in[l] >= d3_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int l = 0; l < LANES; l++) begin
            dr_ff[0][l] <= r4_in[l];
            dl_ff[0][l] <= num4[l][QUO_W-1:0];
            dq_ff[0][l] <= '0;
            dd_ff[0][l] <= d3_ff[l];
         end
         dneg_ff[0]  <= neg3_ff;
         dzero_ff[0] <= zero3_ff;
         dhuge_ff[0] <= huge4_in;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar t = 1; t <= QUO_W; t++) begin : g_div
      logic [DEN_W:0]   rs  [LANES];
      logic [LANES-1:0] ge;
      logic [DEN_W:0]   rn  [LANES];

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            rs[l] = {dr_ff[t-1][l], dl_ff[t-1][l][QUO_W-1]};
            ge[l] = rs[l] >= {1'b0, dd_ff[t-1][l]};
            rn[l] = ge[l] ? (rs[l] - {1'b0, dd_ff[t-1][l]}) : rs[l];
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            for (int l = 0; l < LANES; l++) begin
               dr_ff[t][l] <= rn[l][DEN_W-1:0];
               dl_ff[t][l] <= {dl_ff[t-1][l][QUO_W-2:0], 1'b0};
               dq_ff[t][l] <= {dq_ff[t-1][l][QUO_W-2:0], ge[l]};
               dd_ff[t][l] <= dd_ff[t-1][l];
            end
            dneg_ff[t]  <= dneg_ff[t-1];
            dzero_ff[t] <= dzero_ff[t-1];
            dhuge_ff[t] <= dhuge_ff[t-1];
         end
      end
   end

   // saturation, sign and plane stress zeroing
   ies_pkg::result_type             res_in;
   logic [ies_pkg::STRESS_W-1:0]    lim   [LANES];
   logic [ies_pkg::STRESS_W-1:0]    mag   [LANES];
   logic [LANES-1:0]                sat;

   always_comb begin
      res_in.overflow = 1'b0;
      for (int l = 0; l < LANES; l++) begin
         lim[l] = dneg_ff[QUO_W][l] ? ies_pkg::NEG_LIM : ies_pkg::POS_LIM;
         sat[l] = dhuge_ff[QUO_W][l] || (dq_ff[QUO_W][l] > lim[l]);
         mag[l] = sat[l] ? lim[l] : dq_ff[QUO_W][l];
         if (dzero_ff[QUO_W][l]) begin
            res_in.stress[l] = '0;
         end else begin
            res_in.stress[l] = dneg_ff[QUO_W][l] ? (ies_pkg::STRESS_W'(0) - mag[l]) : mag[l];
            res_in.overflow  = res_in.overflow | sat[l];
         end
      end
   end

   // output register with skid word
   ies_pkg::result_type out_ff;
   ies_pkg::result_type skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (rsp_vld_ff && !rsp.ready) begin
         if (leave) begin
            skid_vld_ff <= 1'b1;
         end
      end else if (skid_vld_ff) begin
         rsp_vld_ff  <= 1'b1;
         skid_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= leave;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_vld_ff && !rsp.ready) begin
         if (leave) begin
            skid_ff <= res_in;
         end
      end else begin
         out_ff <= skid_vld_ff ? skid_ff : res_in;
      end
   end

   assign rsp.valid         = rsp_vld_ff;
   assign rsp.stress_xx     = out_ff.stress[0];
   assign rsp.stress_yy     = out_ff.stress[1];
   assign rsp.stress_third  = out_ff.stress[2];
   assign rsp.stress_fourth = out_ff.stress[3];
   assign rsp.stress_fifth  = out_ff.stress[4];
   assign rsp.stress_sixth  = out_ff.stress[5];
   assign rsp.overflow      = out_ff.overflow;

   // checks
   a_out_idle_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp.valid)
      else $error("result valid right after reset");

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_vld_ff)
      else $error("skid word held with empty output register");

   a_skid_catches: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp.ready && leave |=> skid_vld_ff)
      else $error("word leaving the pipeline was dropped");

   for (genvar l = 0; l < LANES; l++) begin : g_chk
      a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
         vld_ff[STAGES-1] && !dhuge_ff[QUO_W][l] |-> dr_ff[QUO_W][l] < dd_ff[QUO_W][l])
         else $error("division remainder not below divisor");
   end

   a_ovf_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.overflow |->
         out_ff.stress[0] == ies_pkg::POS_LIM || out_ff.stress[0] == ies_pkg::NEG_LIM ||
         out_ff.stress[1] == ies_pkg::POS_LIM || out_ff.stress[1] == ies_pkg::NEG_LIM ||
         out_ff.stress[2] == ies_pkg::POS_LIM || out_ff.stress[2] == ies_pkg::NEG_LIM ||
         out_ff.stress[3] == ies_pkg::POS_LIM || out_ff.stress[3] == ies_pkg::NEG_LIM ||
         out_ff.stress[4] == ies_pkg::POS_LIM || out_ff.stress[4] == ies_pkg::NEG_LIM ||
         out_ff.stress[5] == ies_pkg::POS_LIM || out_ff.stress[5] == ies_pkg::NEG_LIM)
      else $error("overflow flagged without a saturated stress");

endmodule
